@@ rtl/core/mstt_pkg.sv @@
`timescale 1ns / 1ps

package mstt_pkg;

    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [2:0] OP_UPDATE   = 3'd0;
    localparam logic [2:0] OP_PERIODIC = 3'd1;
    localparam logic [2:0] OP_MESSAGE  = 3'd2;
    localparam logic [2:0] OP_TENTH    = 3'd3;
    localparam logic [2:0] OP_CACHE    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MS_PER_SECOND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIODIC_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MESSAGE_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TENTH_LIMIT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CACHE_LIMIT    = 3'd5;

    localparam logic [15:0] RST_TICKS_PER_MS   = 16'd100;
    localparam logic [15:0] RST_MS_PER_SECOND  = 16'd1000;
    localparam logic [7:0]  RST_PERIODIC_LIMIT = 8'd79;
    localparam logic [7:0]  RST_MESSAGE_LIMIT  = 8'd49;
    localparam logic [7:0]  RST_TENTH_LIMIT    = 8'd99;
    localparam logic [15:0] RST_CACHE_LIMIT    = 16'd9999;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] tick_count;
    } in_word_t;

    typedef struct packed {
        logic [15:0] leftover_ticks;
        logic [15:0] elapsed_ms;
        logic        expired;
        logic [31:0] seconds;
    } out_word_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } state_t;

endpackage

@@ rtl/core/multi_software_timer_tick.sv @@
`timescale 1ns / 1ps

// Millisecond software timers. An update word divides its raw tick count by ticks_per_ms
// in a single restoring divider that settles one quotient bit per cycle. An update word
// passes from idle through the divide state to the final state, where its result enters
// the output register; a check word goes from idle straight to the final state. The
// block then returns to idle for the next word. One word is in progress at a time, and a new
// word is taken while the previous result still waits in the output register; a result
// that cannot yet enter the output register holds the block in its final state. Configuration
// writes are taken in every cycle and should only be made while the block is idle.
module multi_software_timer_tick (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  mstt_pkg::in_word_t                 in_word,
    output logic                               out_valid,
    input  logic                               out_ready,
    output mstt_pkg::out_word_t                out_word,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mstt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mstt_pkg::CFG_DAT_W-1:0]     cfg_data
);

    mstt_pkg::state_t    state_reg;
    mstt_pkg::state_t    state_next;
    mstt_pkg::in_word_t  item_reg;
    mstt_pkg::out_word_t out_word_reg;
    mstt_pkg::out_word_t out_word_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic [15:0] ticks_per_ms_reg;
    logic [15:0] ms_per_second_reg;
    logic [7:0]  periodic_limit_reg;
    logic [7:0]  message_limit_reg;
    logic [7:0]  tenth_limit_reg;
    logic [15:0] cache_limit_reg;

    logic [7:0]  periodic_reg;
    logic [7:0]  periodic_next;
    logic [7:0]  message_reg;
    logic [7:0]  message_next;
    logic [7:0]  tenth_reg;
    logic [7:0]  tenth_next;
    logic [15:0] cache_reg;
    logic [15:0] cache_next;
    logic [15:0] ms_acc_reg;
    logic [15:0] ms_acc_next;
    logic [31:0] seconds_reg;
    logic [31:0] seconds_next;

    logic                        accept;
    logic                        div_start;
    logic                        div_done;
    logic [mstt_pkg::TICK_W-1:0] div_quo;
    logic [mstt_pkg::TICK_W-1:0] div_rem;
    logic                        finish;
    logic [15:0]                 ms;
    logic [15:0]                 left;

    assign accept    = in_valid && (state_reg == mstt_pkg::S_IDLE);
    assign div_start = accept && (in_word.opcode == mstt_pkg::OP_UPDATE);
    assign finish    = (state_reg == mstt_pkg::S_DONE) && (!out_valid_reg || out_ready);

    mstt_divider #(
        .WIDTH (mstt_pkg::TICK_W)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (in_word.tick_count),
        .divisor   (ticks_per_ms_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mstt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = div_start ? mstt_pkg::S_DIV : mstt_pkg::S_DONE;
                end
            end
            mstt_pkg::S_DIV:
            begin
                if (div_done)
                begin
                    state_next = mstt_pkg::S_DONE;
                end
            end
            mstt_pkg::S_DONE:
            begin
                if (finish)
                begin
                    state_next = mstt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mstt_pkg::S_IDLE;
            end
        endcase
    end

    // A zero divisor passes the tick count straight through as the leftover.
    always_comb
    begin
        if (ticks_per_ms_reg == '0)
        begin
            ms   = '0;
            left = item_reg.tick_count;
        end
        else
        begin
            ms   = div_quo;
            left = div_rem;
        end
    end

    always_comb
    begin
        periodic_next  = periodic_reg;
        message_next   = message_reg;
        tenth_next     = tenth_reg;
        cache_next     = cache_reg;
        ms_acc_next    = ms_acc_reg;
        seconds_next   = seconds_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (finish)
        begin
            out_word_next.leftover_ticks = '0;
            out_word_next.elapsed_ms     = '0;
            out_word_next.expired        = 1'b0;
            case (item_reg.opcode)
                mstt_pkg::OP_UPDATE:
                begin
                    out_word_next.leftover_ticks = left;
                    out_word_next.elapsed_ms     = ms;
                    periodic_next = periodic_reg + ms[7:0];
                    message_next  = message_reg + ms[7:0];
                    tenth_next    = tenth_reg + ms[7:0];
                    cache_next    = cache_reg + ms;
                    if (ms_acc_reg < ms_per_second_reg)
                    begin
                        ms_acc_next = ms_acc_reg + ms;
                    end
                    else
                    begin
                        ms_acc_next  = ms_acc_reg - ms_per_second_reg + ms;
                        seconds_next = seconds_reg + 32'd1;
                    end
                end
                mstt_pkg::OP_PERIODIC:
                begin
                    if (periodic_reg > periodic_limit_reg)
                    begin
                        periodic_next         = '0;
                        out_word_next.expired = 1'b1;
                    end
                end
                mstt_pkg::OP_MESSAGE:
                begin
                    if (message_reg > message_limit_reg)
                    begin
                        message_next          = '0;
                        out_word_next.expired = 1'b1;
                    end
                end
                mstt_pkg::OP_TENTH:
                begin
                    if (tenth_reg > tenth_limit_reg)
                    begin
                        tenth_next            = '0;
                        out_word_next.expired = 1'b1;
                    end
                end
                mstt_pkg::OP_CACHE:
                begin
                    if (cache_reg > cache_limit_reg)
                    begin
                        cache_next            = '0;
                        out_word_next.expired = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            out_word_next.seconds = seconds_next;
            out_valid_next        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mstt_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            periodic_reg  <= '0;
            message_reg   <= '0;
            tenth_reg     <= '0;
            cache_reg     <= '0;
            ms_acc_reg    <= '0;
            seconds_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            periodic_reg  <= periodic_next;
            message_reg   <= message_next;
            tenth_reg     <= tenth_next;
            cache_reg     <= cache_next;
            ms_acc_reg    <= ms_acc_next;
            seconds_reg   <= seconds_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_per_ms_reg   <= mstt_pkg::RST_TICKS_PER_MS;
            ms_per_second_reg  <= mstt_pkg::RST_MS_PER_SECOND;
            periodic_limit_reg <= mstt_pkg::RST_PERIODIC_LIMIT;
            message_limit_reg  <= mstt_pkg::RST_MESSAGE_LIMIT;
            tenth_limit_reg    <= mstt_pkg::RST_TENTH_LIMIT;
            cache_limit_reg    <= mstt_pkg::RST_CACHE_LIMIT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                mstt_pkg::REG_TICKS_PER_MS:   ticks_per_ms_reg   <= cfg_data;
                mstt_pkg::REG_MS_PER_SECOND:  ms_per_second_reg  <= cfg_data;
                mstt_pkg::REG_PERIODIC_LIMIT: periodic_limit_reg <= cfg_data[7:0];
                mstt_pkg::REG_MESSAGE_LIMIT:  message_limit_reg  <= cfg_data[7:0];
                mstt_pkg::REG_TENTH_LIMIT:    tenth_limit_reg    <= cfg_data[7:0];
                mstt_pkg::REG_CACHE_LIMIT:    cache_limit_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_word;
        end
        out_word_reg <= out_word_next;
    end

    assign in_ready  = (state_reg == mstt_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign cfg_ready = 1'b1;

endmodule

@@ rtl/core/mstt_divider.sv @@
`timescale 1ns / 1ps

module mstt_divider #(
    parameter int WIDTH = mstt_pkg::TICK_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] quo_next;
    logic [WIDTH-1:0] divisor_reg;
    logic [WIDTH-1:0] divisor_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;

    // One quotient bit is settled per cycle by a trial subtraction.
    always_comb
    begin
        shifted      = {rem_reg, quo_reg[WIDTH-1]};
        diff         = shifted - {1'b0, divisor_reg};
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            count_next   = CW'(WIDTH);
            rem_next     = '0;
            quo_next     = dividend;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[WIDTH])
            begin
                rem_next = diff[WIDTH-1:0];
            end
            else
            begin
                rem_next = shifted[WIDTH-1:0];
            end
            quo_next   = {quo_reg[WIDTH-2:0], ~diff[WIDTH]};
            count_next = count_reg - 1'b1;
            if (count_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
